@@ rtl/hbd_pkg.sv @@
// Shared types and constants for the 2:1 halfband decimator.
`default_nettype none

package hbd_pkg;

    localparam int CFG_W          = 6;
    localparam int MAX_TAPS_DEF   = 32;
    localparam int SAMPLE_W_DEF   = 16;
    localparam int COEF_W_DEF     = 18;
    localparam logic [CFG_W-1:0] FILT_LEN_RST = CFG_W'(15);

    // Item kinds carried in tuser
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } t_seq_state;

    // Control that rides along the MAC pipeline with each read
    typedef struct packed {
        logic vld;
        logic first;
    } t_mac_ctl;

endpackage

`default_nettype wire

@@ rtl/hbd_dline.sv @@
// Complex delay line memory: one write port, two registered read ports, zero until written.
`default_nettype none

module hbd_dline #(
    parameter int DEPTH = 32,
    parameter int DW    = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [DW-1:0]            o_rdata0,
    output logic      [DW-1:0]            o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0] r_q0;
    logic [DW-1:0] r_q1;
    logic          r_v0;
    logic          r_v1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0 <= r_mem[i_raddr0];
        r_q1 <= r_mem[i_raddr1];
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_v0 <= r_valid[i_raddr0];
            r_v1 <= r_valid[i_raddr1];
        end
    end

    assign o_rdata0 = r_v0 ? r_q0 : '0;
    assign o_rdata1 = r_v1 ? r_q1 : '0;

endmodule

`default_nettype wire

@@ rtl/hbd_cmac.sv @@
// Shared complex multiply-accumulate with pre-adder, then round and saturate.
`default_nettype none

module hbd_cmac #(
    parameter int SW   = 16,
    parameter int CW   = 18,
    parameter int HALF = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire hbd_pkg::t_mac_ctl      i_ctl,
    input  wire logic signed [CW-1:0]   i_coef,
    input  wire logic        [2*SW-1:0] i_fir_a,
    input  wire logic        [2*SW-1:0] i_fir_b,
    input  wire logic        [2*SW-1:0] i_tap,
    output logic             [2*SW-1:0] o_res
);

    import hbd_pkg::*;

    localparam int PW   = SW + CW + 1;
    localparam int ACCW = PW + $clog2(HALF + 1);
    localparam logic [ACCW:0] RND_K = (ACCW+1)'(1) << (CW - 1);
    localparam logic signed [ACCW:0] Q_MAX = (ACCW+1)'((1 << (SW - 1)) - 1);
    localparam logic signed [ACCW:0] Q_MIN = -Q_MAX - (ACCW+1)'(1);

    t_mac_ctl r_s1;
    t_mac_ctl r_s2;

    logic signed [SW-1:0]   w_a    [2];
    logic signed [SW-1:0]   w_b    [2];
    logic signed [SW-1:0]   w_t    [2];
    logic signed [SW:0]     w_sum  [2];
    logic signed [PW-1:0]   w_prod [2];
    logic signed [PW-1:0]   r_prod [2];
    logic signed [ACCW-1:0] r_acc  [2];
    logic        [ACCW:0]   w_rnd  [2];
    logic signed [ACCW:0]   w_q    [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_ctl;
            r_s2 <= r_s1;
        end
    end

    // Stage 1: pre-add the symmetric pair and multiply, or scale the center tap
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_a[p]   = i_fir_a[p*SW +: SW];
            w_b[p]   = i_fir_b[p*SW +: SW];
            w_t[p]   = i_tap[p*SW +: SW];
            w_sum[p] = (SW+1)'(w_a[p]) + (SW+1)'(w_b[p]);
            if (r_s1.first) begin
                w_prod[p] = PW'(w_t[p]) <<< (CW - 1);
            end else begin
                w_prod[p] = PW'(i_coef) * PW'(w_sum[p]);
            end
        end
    end

    // Stage 2: accumulate; the center tap starts a fresh sum
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < 2; p++) begin
            if (r_s1.vld) begin
                r_prod[p] <= w_prod[p];
            end
            if (r_s2.vld) begin
                if (r_s2.first) begin
                    r_acc[p] <= ACCW'(r_prod[p]);
                end else begin
                    r_acc[p] <= r_acc[p] + ACCW'(r_prod[p]);
                end
            end
        end
    end

    // Round half up, drop the coefficient fraction, clamp to the sample range
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_rnd[p] = (ACCW+1)'(r_acc[p]) + RND_K;
            w_q[p]   = $signed(w_rnd[p]) >>> CW;
            if (w_q[p] > Q_MAX) begin
                o_res[p*SW +: SW] = SW'(Q_MAX);
            end else if (w_q[p] < Q_MIN) begin
                o_res[p*SW +: SW] = SW'(Q_MIN);
            end else begin
                o_res[p*SW +: SW] = SW'(w_q[p]);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/hbd_ctrl.sv @@
// Sequencer: write pointer, tap address generation and MAC issue control.
`default_nettype none

module hbd_ctrl #(
    parameter int MAX_TAPS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [hbd_pkg::CFG_W-1:0]          i_filt_len,
    input  wire logic                               i_out_free,
    output logic                                    o_ready,
    output logic                                    o_load,
    output logic                                    o_fir_even,
    output logic [$clog2(MAX_TAPS)-1:0]             o_wr_addr,
    output logic [$clog2(MAX_TAPS)-1:0]             o_rd_addr0,
    output logic [$clog2(MAX_TAPS)-1:0]             o_rd_addr1,
    output logic [$clog2(MAX_TAPS/2)-1:0]           o_coef_idx,
    output hbd_pkg::t_mac_ctl                       o_mac_ctl
);

    import hbd_pkg::*;

    localparam int AW   = $clog2(MAX_TAPS);
    localparam int NW   = $clog2(MAX_TAPS + 1);
    localparam int CIW  = $clog2(MAX_TAPS / 2);
    localparam int TW   = (NW > CFG_W) ? NW : CFG_W;
    localparam int SW2  = NW + 1;

    t_seq_state r_state;
    t_seq_state n_state;
    logic [NW-1:0] r_cnt;
    logic [NW-1:0] n_cnt;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] w_wp_dec;
    logic [TW-1:0] w_nt_ext;
    logic [NW-1:0] w_n;
    logic [NW-1:0] w_half;
    logic [NW-1:0] w_off;
    logic [NW-1:0] w_k;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [NW-1:0] ofs);
        logic [SW2-1:0] s;
        s = SW2'(base) + SW2'(ofs);
        if (s >= SW2'(MAX_TAPS)) begin
            s = s - SW2'(MAX_TAPS);
        end
        return AW'(s);
    endfunction

    // Zero taps acts as one; lengths past the line depth clamp to it
    assign w_nt_ext = TW'(i_filt_len);
    always_comb begin
        if (w_nt_ext == '0) begin
            w_n = NW'(1);
        end else if (w_nt_ext > TW'(MAX_TAPS)) begin
            w_n = NW'(MAX_TAPS);
        end else begin
            w_n = NW'(w_nt_ext);
        end
    end

    assign w_half     = w_n >> 1;
    assign o_fir_even = ~w_n[0];
    assign w_off      = w_n[0] ? NW'(1) : NW'(0);
    assign w_k        = r_cnt - NW'(1);
    assign w_wp_dec   = (r_wp == '0) ? AW'(MAX_TAPS - 1) : r_wp - AW'(1);
    assign o_wr_addr  = w_wp_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_start) begin
                r_wp <= w_wp_dec;
            end
        end
    end

    // Next state: center tap, then one issue per coefficient pair, drain, hand off
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_cnt == w_half) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            S_DRAIN: begin
                if (r_cnt == NW'(1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ready         = 1'b0;
        o_load          = 1'b0;
        o_mac_ctl       = '0;
        o_rd_addr0      = f_wrap(r_wp, w_k + w_off);
        o_rd_addr1      = f_wrap(r_wp, w_n - NW'(1) - w_k);
        o_coef_idx      = CIW'(w_k);
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_ISSUE: begin
                o_mac_ctl.vld   = 1'b1;
                o_mac_ctl.first = (r_cnt == '0);
                if (r_cnt == '0) begin
                    o_rd_addr0 = f_wrap(r_wp, w_half);
                end
            end
            S_DRAIN: begin
                o_ready = 1'b0;
            end
            S_DONE: begin
                o_load = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/halfband_decimator_2to1.sv @@
// Top level of the complex 2:1 halfband decimator with one shared complex MAC.
`default_nettype none

// Complex 2:1 polyphase halfband decimator. Each input item is a complex
// sample (tuser = 0) or a coefficient write (tuser = 1). Samples alternate
// even and odd: an even sample is held, and the odd one pushes the pair into
// the even and odd delay lines and yields one output item, Q1.15, rounded half
// up and saturated. The filter length comes from the filter length register
// (write it through i_cfg_we / i_cfg_wdata while idle); its parity picks the
// branch. Coefficient writes and even samples need no MAC pass. After an odd
// sample is accepted, the shared complex MAC makes one pass over the center tap
// and the floor(N/2) coefficient pairs, where N is the clamped filter length
// (two delay line reads a cycle); the pipeline then drains and the result is
// handed to the output register before the next item is accepted. The output
// register lets the next item in while a result waits; a second result waits
// in the sequencer until it drains.
// Delay lines read as zero after reset without any clearing pass.
module halfband_decimator_2to1 #(
    parameter int MAX_TAPS     = hbd_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = hbd_pkg::SAMPLE_W_DEF,
    parameter int COEF_WIDTH   = hbd_pkg::COEF_W_DEF,
    localparam int CIW_P  = $clog2(MAX_TAPS / 2),
    localparam int IN_DW  = ((2 * SAMPLE_WIDTH + CIW_P + COEF_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // sample_re, sample_im, coef_index, coef_value, zero pad
    input  wire logic [IN_DW-1:0]          i_s_axis_tdata,
    // mode
    input  wire logic                      i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // out_re, out_im, zero pad
    output logic [OUT_DW-1:0]              o_m_axis_tdata,
    input  wire logic                      i_cfg_we,
    input  wire logic [hbd_pkg::CFG_W-1:0] i_cfg_wdata
);

    import hbd_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = COEF_WIDTH;
    localparam int HALF = MAX_TAPS / 2;
    localparam int AW   = $clog2(MAX_TAPS);
    localparam int CIW  = CIW_P;

    logic [CFG_W-1:0]     r_filt_len;
    logic                 r_phase;
    logic [2*SW-1:0]      r_held;
    logic                 r_out_vld;
    logic [2*SW-1:0]      r_out;
    logic signed [CW-1:0] r_coef_mem [HALF];
    logic signed [CW-1:0] r_coef;

    logic                 w_acc;
    logic                 w_is_coef;
    logic                 w_start;
    logic [2*SW-1:0]      w_sample;
    logic [CIW-1:0]       w_cidx;
    logic signed [CW-1:0] w_cval;
    logic                 w_ready;
    logic                 w_load;
    logic                 w_out_free;
    logic                 w_fir_even;
    logic [AW-1:0]        w_wr_addr;
    logic [AW-1:0]        w_rd_addr0;
    logic [AW-1:0]        w_rd_addr1;
    logic [CIW-1:0]       w_coef_idx;
    t_mac_ctl             w_mac_ctl;
    logic [2*SW-1:0]      w_even_q0;
    logic [2*SW-1:0]      w_even_q1;
    logic [2*SW-1:0]      w_odd_q0;
    logic [2*SW-1:0]      w_odd_q1;
    logic [2*SW-1:0]      w_fir_a;
    logic [2*SW-1:0]      w_fir_b;
    logic [2*SW-1:0]      w_tap;
    logic [2*SW-1:0]      w_res;

    // Unpack the input item; the complex value travels as {im, re}
    assign w_sample = i_s_axis_tdata[2*SW-1:0];
    assign w_cidx   = i_s_axis_tdata[2*SW +: CIW];
    assign w_cval   = i_s_axis_tdata[2*SW+CIW +: CW];

    assign o_s_axis_tready = w_ready;
    assign w_acc     = i_s_axis_tvalid && w_ready;
    assign w_is_coef = (i_s_axis_tuser == MODE_COEF);
    // The odd sample of a pair launches one output computation
    assign w_start   = w_acc && !w_is_coef && r_phase;
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_len <= FILT_LEN_RST;
            r_phase    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_filt_len <= i_cfg_wdata;
            end
            if (w_acc && (i_s_axis_tuser == MODE_SAMPLE)) begin
                r_phase <= ~r_phase;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: held even sample, result register, coefficient table
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_is_coef && !r_phase) begin
            r_held <= w_sample;
        end
        if (w_load) begin
            r_out <= w_res;
        end
        if (w_acc && w_is_coef && ((CIW+1)'(w_cidx) < (CIW+1)'(HALF))) begin
            r_coef_mem[w_cidx] <= w_cval;
        end
        r_coef <= r_coef_mem[w_coef_idx];
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_DW'(r_out);

    hbd_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_filt_len (r_filt_len),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_load     (w_load),
        .o_fir_even (w_fir_even),
        .o_wr_addr  (w_wr_addr),
        .o_rd_addr0 (w_rd_addr0),
        .o_rd_addr1 (w_rd_addr1),
        .o_coef_idx (w_coef_idx),
        .o_mac_ctl  (w_mac_ctl)
    );

    hbd_dline #(
        .DEPTH (MAX_TAPS),
        .DW    (2 * SW)
    ) u_even_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_start),
        .i_waddr  (w_wr_addr),
        .i_wdata  (r_held),
        .i_raddr0 (w_rd_addr0),
        .i_raddr1 (w_rd_addr1),
        .o_rdata0 (w_even_q0),
        .o_rdata1 (w_even_q1)
    );

    hbd_dline #(
        .DEPTH (MAX_TAPS),
        .DW    (2 * SW)
    ) u_odd_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_start),
        .i_waddr  (w_wr_addr),
        .i_wdata  (w_sample),
        .i_raddr0 (w_rd_addr0),
        .i_raddr1 (w_rd_addr1),
        .o_rdata0 (w_odd_q0),
        .o_rdata1 (w_odd_q1)
    );

    // Even length filters over the even line and taps the odd center; odd length swaps
    assign w_fir_a = w_fir_even ? w_even_q0 : w_odd_q0;
    assign w_fir_b = w_fir_even ? w_even_q1 : w_odd_q1;
    assign w_tap   = w_fir_even ? w_odd_q0  : w_even_q0;

    hbd_cmac #(
        .SW   (SW),
        .CW   (CW),
        .HALF (HALF)
    ) u_cmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (r_coef),
        .i_fir_a (w_fir_a),
        .i_fir_b (w_fir_b),
        .i_tap   (w_tap),
        .o_res   (w_res)
    );

    // An odd sample starts a computation, so the next cycle must not accept
    a_busy_after_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_s_axis_tready)
        else $error("input accepted right after a computation started");

    // Coefficient writes leave the sample phase alone
    a_phase_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_coef) |=> $stable(r_phase))
        else $error("sample phase moved on a coefficient write");

    // A result appears only through a sequencer hand-off
    a_out_from_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_load))
        else $error("output valid without a result hand-off");

    // Never overwrite a result that has not been taken
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_vld || i_m_axis_tready))
        else $error("result register overwritten while full");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the complex 2:1 halfband decimator.
`default_nettype none

module tb_top;
    import hbd_pkg::*;

    localparam int TAPS_MAX        = 32;
    localparam int COEF_SLOTS      = TAPS_MAX / 2;
    localparam int IN_BITS         = 56;
    localparam int OUT_BITS        = 32;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_OFF_CYCLES = 300;
    // Worst item runs the MAC over all floor(32/2) coefficient pairs; leave room for the output register.
    localparam int SETTLE_CYCLES   = 40;
    localparam int STALL_LIMIT     = 5000;

    typedef struct {
        logic               mode;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [3:0]         cidx;
        logic signed [17:0] cval;
    } t_hb_item;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } t_hb_out;

    // DUT connections; the ones the bench drives are known from time zero
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                s_tvalid        = 1'b0;
    wire logic           s_tready;
    logic [IN_BITS-1:0]  s_tdata         = '0;
    logic                s_tuser         = MODE_SAMPLE;
    wire logic           m_tvalid;
    logic                m_tready        = 1'b0;
    wire logic [OUT_BITS-1:0] m_tdata;
    logic                cfg_we          = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata       = '0;

    t_hb_item pending_items[$];
    t_hb_out  expected_outputs[$];
    int       error_count    = 0;
    int       src_idle_pct   = 0;
    int       sink_stall_pct = 0;
    int       hold_req       = 0;
    int       hold_seen      = 0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    // Shadow of the filter state
    logic signed [15:0] even_line [TAPS_MAX][2];
    logic signed [15:0] odd_line  [TAPS_MAX][2];
    logic signed [15:0] held_pair [2];
    logic signed [17:0] coef_mem  [COEF_SLOTS];
    logic [4:0]         line_wp    = '0;
    logic               odd_next   = 1'b0;
    logic [CFG_W-1:0]   model_taps = FILT_LEN_RST;

    halfband_decimator_2to1 u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // sample_re, sample_im, coef_index, coef_value, zero pad
        .i_s_axis_tdata  (s_tdata),
        // mode
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // out_re, out_im, zero pad
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < TAPS_MAX; i++) begin
            even_line[i][0] = '0;
            even_line[i][1] = '0;
            odd_line[i][0]  = '0;
            odd_line[i][1]  = '0;
        end
        held_pair[0] = '0;
        held_pair[1] = '0;
        for (int i = 0; i < COEF_SLOTS; i++) coef_mem[i] = '0;
    end

    // Round half up, then clamp to Q1.15.
    function automatic logic signed [15:0] round_saturate(longint acc);
        longint q;
        q = (acc + 64'sd131072) >>> 18;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Advance the shadow filter by one accepted item; flag and return any output.
    task automatic decimate_step(input t_hb_item it, output bit has_out, output t_hb_out res);
        int      n;
        int      half;
        int      off;
        bit      fir_even;
        longint  acc;
        longint  pair_sum;
        longint  center;
        logic [4:0] ia;
        logic [4:0] ib;
        logic signed [15:0] outs [2];
        has_out = 1'b0;
        res.re  = '0;
        res.im  = '0;
        if (it.mode == MODE_COEF) begin
            coef_mem[it.cidx] = it.cval;
            return;
        end
        if (!odd_next) begin
            held_pair[0] = it.re;
            held_pair[1] = it.im;
            odd_next     = 1'b1;
            return;
        end
        // Push the pair; newest entry sits at the write pointer.
        line_wp = line_wp - 5'd1;
        even_line[line_wp][0] = held_pair[0];
        even_line[line_wp][1] = held_pair[1];
        odd_line[line_wp][0]  = it.re;
        odd_line[line_wp][1]  = it.im;
        odd_next = 1'b0;

        n = int'(model_taps);
        if (n == 0) n = 1;
        if (n > TAPS_MAX) n = TAPS_MAX;
        half     = n / 2;
        fir_even = (n % 2) == 0;
        off      = fir_even ? 0 : 1;
        for (int p = 0; p < 2; p++) begin
            ia = 5'(int'(line_wp) + half);
            center = fir_even ? longint'(odd_line[ia][p]) : longint'(even_line[ia][p]);
            acc = center * 64'sd131072;
            for (int k = 0; k < half; k++) begin
                ia = 5'(int'(line_wp) + k + off);
                ib = 5'(int'(line_wp) + n - 1 - k);
                if (fir_even)
                    pair_sum = longint'(even_line[ia][p]) + longint'(even_line[ib][p]);
                else
                    pair_sum = longint'(odd_line[ia][p]) + longint'(odd_line[ib][p]);
                acc += longint'(coef_mem[k]) * pair_sum;
            end
            outs[p] = round_saturate(acc);
        end
        res.re  = outs[0];
        res.im  = outs[1];
        has_out = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Driver: advance to the next pending item once the current one is taken.
    always @(posedge i_clk) begin : drive_items
        t_hb_item nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.mode;
                s_tdata  <= {2'b00, nxt.cval, nxt.cidx, nxt.im, nxt.re};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: check outputs against the oldest expectation, then predict from inputs.
    always @(posedge i_clk) begin : watch_items
        t_hb_item acc_item;
        t_hb_out  want;
        t_hb_out  got;
        bit       has_out;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.re = m_tdata[15:0];
                got.im = m_tdata[31:16];
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("output with none pending: re=%0d im=%0d",
                                              got.re, got.im));
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.re !== want.re)
                        report_mismatch($sformatf("out_re got %0d want %0d", got.re, want.re));
                    if (got.im !== want.im)
                        report_mismatch($sformatf("out_im got %0d want %0d", got.im, want.im));
                end
            end
            if (cfg_we) model_taps = cfg_wdata;
            if (s_tvalid && s_tready) begin
                acc_item.mode = s_tuser;
                acc_item.re   = s_tdata[15:0];
                acc_item.im   = s_tdata[31:16];
                acc_item.cidx = s_tdata[35:32];
                acc_item.cval = s_tdata[53:36];
                decimate_step(acc_item, has_out, want);
                if (has_out) expected_outputs.push_back(want);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_hb_item sample_item(logic signed [15:0] re, logic signed [15:0] im);
        t_hb_item it;
        it.mode = MODE_SAMPLE;
        it.re   = re;
        it.im   = im;
        it.cidx = 4'(($urandom));
        it.cval = 18'($urandom);
        return it;
    endfunction

    function automatic t_hb_item coef_item(logic [3:0] idx, logic signed [17:0] val);
        t_hb_item it;
        it.mode = MODE_COEF;
        it.re   = 16'($urandom);
        it.im   = 16'($urandom);
        it.cidx = idx;
        it.cval = val;
        return it;
    endfunction

    // Mostly random samples, with full-scale and zero values mixed in.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [17:0] pick_coef(bit wide);
        if (wide) return 18'($urandom);
        return 18'($signed($urandom_range(16383)) - 8192);
    endfunction

    task automatic write_filt_len(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain everything, then let the MAC settle before touching the register.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : run_stimulus
        logic [CFG_W-1:0] tap_plan [8];
        int               idle_plan [4][2];
        logic signed [17:0] directed_coefs [COEF_SLOTS];
        int               mode_sel;

        tap_plan = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd31, 6'd63, 6'd33, 6'd8};
        // sender idle percent, receiver stall percent
        idle_plan = '{'{0, 0}, '{53, 0}, '{0, 53}, '{10, 10}};
        directed_coefs = '{-18'sd131072, 18'sd131071, 18'sd0, 18'sd1, -18'sd1, 18'sd65536,
                           -18'sd65536, 18'sd43690, -18'sd43691, 18'sd21845, 18'sd12345,
                           -18'sd777, 18'sd3000, -18'sd3000, 18'sd100, 18'sd5};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the whole coefficient table first, so no unwritten entry is read.
        @(negedge i_clk);
        for (int i = 0; i < COEF_SLOTS; i++)
            pending_items.push_back(coef_item(4'(i), directed_coefs[i]));
        // Full-scale pairs at the reset filter length
        pending_items.push_back(sample_item(16'sh7fff, 16'sh8000));
        pending_items.push_back(sample_item(16'sh7fff, 16'sh8000));
        pending_items.push_back(sample_item(16'sh8000, 16'sh7fff));
        // Coefficient write between the even and odd halves keeps the phase
        pending_items.push_back(coef_item(4'd0, 18'sd131071));
        pending_items.push_back(sample_item(16'sh8000, 16'sh7fff));
        pending_items.push_back(sample_item(-16'sd1, 16'sd1));
        pending_items.push_back(sample_item(16'sd0, -16'sd1));
        pending_items.push_back(sample_item(16'sd21845, -16'sd21846));
        pending_items.push_back(sample_item(-16'sd21846, 16'sd21845));
        wait_drained();

        // Random phases: each with its own filter length and idling pattern
        for (int ph = 0; ph < 8; ph++) begin
            write_filt_len(tap_plan[ph]);
            @(negedge i_clk);
            mode_sel       = (ph + 1) % 4;
            src_idle_pct   = idle_plan[mode_sel][0];
            sink_stall_pct = idle_plan[mode_sel][1];
            // Long receiver hold-off while the sender keeps pushing
            if (ph == 0 || ph == 4) hold_req <= hold_req + 1;
            // Reload the table: small taps keep outputs in range, wide ones saturate
            for (int i = 0; i < COEF_SLOTS; i++)
                pending_items.push_back(coef_item(4'(i), pick_coef(ph % 2 == 1)));
            for (int n = 0; n < ITEMS_PER_PHASE - COEF_SLOTS; n++) begin
                if ($urandom_range(99) < 6)
                    pending_items.push_back(coef_item(4'($urandom), pick_coef($urandom_range(1))));
                else
                    pending_items.push_back(sample_item(pick_sample(), pick_sample()));
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
